// ===== rtl/llf_pkg.sv =====
package llf_pkg;

	localparam int PIX_W      = 8;
	localparam int FW_W       = 12;
	localparam int FH_W       = 16;
	localparam int ROW_W      = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = FW_W'(640);
	localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = FH_W'(480);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

	// per-item decisions taken at accept, used in the following cycle
	typedef struct packed {
		logic emit;
		logic last;
		logic use_up;
		logic use_dn;
		logic use_left;
		logic use_right;
	} ctl_t;

	typedef struct packed {
		logic [PIX_W-1:0] filtered_value;
		logic             last_of_frame;
	} res_t;

endpackage

// ===== rtl/llf_ifs.sv =====
interface llf_pix_if import llf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, output op, output pixel_value, input ready);
	modport sink (input valid, input op, input pixel_value, output ready);
endinterface

interface llf_res_if import llf_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] filtered_value;
	logic             last_of_frame;

	modport source (output valid, output filtered_value, output last_of_frame, input ready);
	modport sink (input valid, input filtered_value, input last_of_frame, output ready);
endinterface

// ===== rtl/llf_line_store.sv =====
module llf_line_store import llf_pkg::*; #(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic             clk,
	input  logic [AW-1:0]    rd_addr,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [PIX_W-1:0] wr_older,
	input  logic [PIX_W-1:0] wr_newer,
	output logic [PIX_W-1:0] rd_older,
	output logic [PIX_W-1:0] rd_newer
);

	logic [PIX_W-1:0] older_mem [DEPTH];
	logic [PIX_W-1:0] newer_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr] <= wr_older;
			newer_mem[wr_addr] <= wr_newer;
		end
	end

	always_ff @(posedge clk) begin
		rd_older <= older_mem[rd_addr];
		rd_newer <= newer_mem[rd_addr];
	end

endmodule

// ===== rtl/llf_window.sv =====
module llf_window import llf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  ctl_t             ctl,
	input  logic [PIX_W-1:0] up2,
	input  logic [PIX_W-1:0] up1,
	input  logic [PIX_W-1:0] pix,
	output logic [PIX_W-1:0] result
);

	// only the taps that feed the kernel: newest column and middle of the one before
	logic [PIX_W-1:0] top2_q, mid2_q, bot2_q, mid1_q;
	logic [10:0]      pos, neg, diff;

	always_comb begin
		pos  = {1'b0, mid2_q, 2'b00};
		neg  = (ctl.use_up    ? 11'(top2_q) : 11'd0)
		     + (ctl.use_dn    ? 11'(bot2_q) : 11'd0)
		     + (ctl.use_left  ? 11'(mid1_q) : 11'd0)
		     + (ctl.use_right ? 11'(up1)    : 11'd0);
		diff = pos - neg;
		if (neg > pos) begin
			result = '0;
		end else if (diff > 11'(PIX_MAX)) begin
			result = PIX_MAX;
		end else begin
			result = diff[PIX_W-1:0];
		end
	end

	// shift one column in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top2_q <= '0;
			mid2_q <= '0;
			bot2_q <= '0;
			mid1_q <= '0;
		end else if (step) begin
			mid1_q <= mid2_q;
			top2_q <= up2;
			mid2_q <= up1;
			bot2_q <= pix;
		end
	end

endmodule

// ===== rtl/llf_res_fifo.sv =====
module llf_res_fifo import llf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  res_t               push_data,
	output logic [FIFO_CW-1:0] count,
	llf_res_if.source          res_out
);

	res_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;

	assign pop                    = res_out.valid && res_out.ready;
	assign res_out.valid          = (cnt_q != '0);
	assign res_out.filtered_value = mem[rd_ptr_q].filtered_value;
	assign res_out.last_of_frame  = mem[rd_ptr_q].last_of_frame;
	assign count                  = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

endmodule

// ===== rtl/laplacian_3x3_image_filter.sv =====
// Channel   Dir  Payload                            Accepted when
// pix_in    in   op, pixel_value                    pix_in.valid && pix_in.ready
// res_out   out  filtered_value, last_of_frame      res_out.valid && res_out.ready
// cfg       in   cfg_index, cfg_data                cfg_we
//
// One item per clock while pix_in.ready is high. An accepted item reads both line stores in its cycle; the
// next cycle forms the kernel and, for an item that emits, pushes the result into a four-entry result queue.
// pix_in.ready drops only when the queued results plus the item in flight fill the
// queue, so a stalled res_out throttles the input after three waiting results.
// Reset loads 640 x 480 and clears counters, window and queue; line stores are not
// cleared (border masking hides stale entries), so there is no clearing pass.
module laplacian_3x3_image_filter import llf_pkg::*; #(
	parameter int MAX_ROW_PIXELS = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	llf_pix_if.sink               pix_in,
	llf_res_if.source             res_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = $clog2(MAX_ROW_PIXELS);
	localparam int WID_W = $clog2(MAX_ROW_PIXELS + 1);
	localparam int CMP_W = (WID_W > FW_W) ? WID_W : FW_W;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [COL_W-1:0] arr_col_q, emit_col_q;
	logic [ROW_W-1:0] arr_row_q;
	logic [FH_W-1:0]  emit_row_q;

	logic [CMP_W-1:0] fw_ext;
	logic [WID_W-1:0] w_eff;
	logic [FH_W-1:0]  h_eff;
	logic [COL_W-1:0] col;
	logic             col_wrap, ecol_end, erow_end;
	logic             acc;
	ctl_t             ctl_s0;
	logic [PIX_W-1:0] pix_s0;

	logic             valid_s1;
	ctl_t             ctl_s1;
	logic [COL_W-1:0] addr_s1;
	logic [PIX_W-1:0] pix_s1;
	logic             fwd_s1;
	logic [PIX_W-1:0] fwd_old_s1, fwd_new_s1;
	logic [PIX_W-1:0] rd_older, rd_newer, up2_s1, up1_s1;
	logic [PIX_W-1:0] kern;
	logic [FIFO_CW-1:0] q_count;
	res_t             push_data;

	// effective frame size
	always_comb begin
		fw_ext = CMP_W'(fw_q);
		if (fw_q == '0) begin
			w_eff = WID_W'(1);
		end else if (fw_ext > CMP_W'(MAX_ROW_PIXELS)) begin
			w_eff = WID_W'(MAX_ROW_PIXELS);
		end else begin
			w_eff = WID_W'(fw_ext);
		end
		h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
	end

	always_comb begin
		col      = (WID_W'(arr_col_q) >= w_eff) ? '0 : arr_col_q;
		col_wrap = (WID_W'(col) + WID_W'(1)) >= w_eff;
		ecol_end = (WID_W'(emit_col_q) + WID_W'(1)) >= w_eff;
		erow_end = (ROW_W'(emit_row_q) + ROW_W'(1)) >= ROW_W'(h_eff);

		ctl_s0.emit      = (arr_row_q >= ROW_W'(2)) || (arr_row_q == ROW_W'(1) && col != '0);
		ctl_s0.last      = erow_end && ecol_end;
		ctl_s0.use_up    = (emit_row_q != '0);
		ctl_s0.use_dn    = !erow_end;
		ctl_s0.use_left  = (emit_col_q != '0);
		ctl_s0.use_right = (col != '0) && !ecol_end;

		pix_s0 = (pix_in.op == OP_FLUSH) ? '0 : pix_in.pixel_value;
	end

	// queue room for everything queued plus the item in flight
	assign pix_in.ready = (FIFO_CW'(q_count) + FIFO_CW'(valid_s1)) < FIFO_CW'(FIFO_DEPTH);
	assign acc          = pix_in.valid && pix_in.ready;

	// configuration and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q       <= FRAME_WIDTH_RST;
			fh_q       <= FRAME_HEIGHT_RST;
			arr_col_q  <= '0;
			arr_row_q  <= '0;
			emit_col_q <= '0;
			emit_row_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					fw_q       <= cfg_data[FW_W-1:0];
					arr_col_q  <= '0;
					arr_row_q  <= '0;
					emit_col_q <= '0;
					emit_row_q <= '0;
				end
				REG_FRAME_HEIGHT: begin
					fh_q       <= cfg_data[FH_W-1:0];
					arr_col_q  <= '0;
					arr_row_q  <= '0;
					emit_col_q <= '0;
					emit_row_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (col_wrap) begin
				arr_col_q <= '0;
				arr_row_q <= arr_row_q + 1'b1;
			end else begin
				arr_col_q <= col + 1'b1;
			end
			if (ctl_s0.emit) begin
				if (ctl_s0.last) begin
					arr_col_q  <= '0;
					arr_row_q  <= '0;
					emit_col_q <= '0;
					emit_row_q <= '0;
				end else if (ecol_end) begin
					emit_col_q <= '0;
					emit_row_q <= emit_row_q + 1'b1;
				end else begin
					emit_col_q <= emit_col_q + 1'b1;
				end
			end
		end
	end

	// stage 1: line store data, with the previous item's write forwarded
	assign up2_s1 = fwd_s1 ? fwd_old_s1 : rd_older;
	assign up1_s1 = fwd_s1 ? fwd_new_s1 : rd_newer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1     <= ctl_s0;
			addr_s1    <= col;
			pix_s1     <= pix_s0;
			fwd_s1     <= valid_s1 && (addr_s1 == col);
			fwd_old_s1 <= up1_s1;
			fwd_new_s1 <= pix_s1;
		end
	end

	llf_line_store #(
		.DEPTH (MAX_ROW_PIXELS),
		.AW    (COL_W)
	) u_line_store (
		.clk      (clk),
		.rd_addr  (col),
		.wr_en    (valid_s1),
		.wr_addr  (addr_s1),
		.wr_older (up1_s1),
		.wr_newer (pix_s1),
		.rd_older (rd_older),
		.rd_newer (rd_newer)
	);

	llf_window u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1),
		.ctl    (ctl_s1),
		.up2    (up2_s1),
		.up1    (up1_s1),
		.pix    (pix_s1),
		.result (kern)
	);

	assign push_data.filtered_value = kern;
	assign push_data.last_of_frame  = ctl_s1.last;

	llf_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1 && ctl_s1.emit),
		.push_data (push_data),
		.count     (q_count),
		.res_out   (res_out)
	);

	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(arr_col_q) < w_eff)
		else $error("arrival column outside the row");

	a_stall_has_results: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> res_out.valid)
		else $error("input stalled with no result waiting");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && ctl_s0.emit && ctl_s0.last) |=>
		(arr_col_q == '0 && arr_row_q == '0 && emit_col_q == '0 && emit_row_q == '0))
		else $error("frame end did not restart the counters");

endmodule
